@@ design/binary_to_roman_numeral_stream_defines.svh @@
// assertion macros for the binary to roman numeral stream block
// uses clk and arst_n of the module that includes this file
`ifndef BINARY_TO_ROMAN_NUMERAL_STREAM_DEFINES_SVH
`define BINARY_TO_ROMAN_NUMERAL_STREAM_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define B2RN_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B2RN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/b2rn_pkg.sv @@
// shared types and constants of the binary to roman numeral stream block
// no dependencies
package b2rn_pkg;

	localparam int VALUE_W  = 12;
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 2;
	localparam int DIGITS   = 4;

	localparam logic [VALUE_W-1:0] ROMAN_MAX = 12'd3999;

	localparam logic [CHAR_W-1:0] SYM_I = 8'h49;
	localparam logic [CHAR_W-1:0] SYM_V = 8'h56;
	localparam logic [CHAR_W-1:0] SYM_X = 8'h58;
	localparam logic [CHAR_W-1:0] SYM_L = 8'h4C;
	localparam logic [CHAR_W-1:0] SYM_C = 8'h43;
	localparam logic [CHAR_W-1:0] SYM_D = 8'h44;
	localparam logic [CHAR_W-1:0] SYM_M = 8'h4D;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic take;   // latch a new input value
		logic load;   // produce the next beat into the output register
	} b2rn_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_last;  // the beat about to be produced ends the numeral
		logic is_ok;    // current item is a real numeral
	} b2rn_sts_t;

	// symbol ladder I V X L C D M, indexed by 2*decade + offset
	function automatic logic [CHAR_W-1:0] roman_sym(input logic [3:0] idx);
		logic [CHAR_W-1:0] s;
		case (idx)
			4'd0:    s = SYM_I;
			4'd1:    s = SYM_V;
			4'd2:    s = SYM_X;
			4'd3:    s = SYM_L;
			4'd4:    s = SYM_C;
			4'd5:    s = SYM_D;
			4'd6:    s = SYM_M;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

@@ design/b2rn_in_if.sv @@
// input channel of the roman numeral stream: one number per beat
// depends on b2rn_pkg
interface b2rn_in_if import b2rn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

@@ design/b2rn_out_if.sv @@
// output channel of the roman numeral stream: one symbol per beat
// depends on b2rn_pkg
interface b2rn_out_if import b2rn_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CHAR_W-1:0]   symbol_char;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source(output valid, output symbol_char, output status, output last, input ready);
	modport sink(input valid, input symbol_char, input status, input last, output ready);
endinterface

@@ design/b2rn_ctrl.sv @@
// controller of the roman numeral stream: item sequencing and output valid
// depends on b2rn_pkg and binary_to_roman_numeral_stream_defines.svh
`include "binary_to_roman_numeral_stream_defines.svh"

module b2rn_ctrl import b2rn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  b2rn_sts_t sts,
	output b2rn_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		cmd.load  = (state_q == S_RUN) && slot_free;
		// next number may enter as the final beat of this one is produced
		in_ready  = (state_q == S_IDLE) || (cmd.load && sts.is_last);
		cmd.take  = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				state_q <= S_RUN;
			end else if (cmd.load && sts.is_last) begin
				state_q <= S_IDLE;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`B2RN_ASSERT(a_no_overwrite, cmd.load, !out_valid_q || out_ready, "beat overwritten while stalled")
	`B2RN_ASSERT(a_idle_quiet, state_q == S_IDLE, !cmd.load, "beat produced with no item in flight")
	`B2RN_ASSERT(a_special_single, cmd.load && !sts.is_ok, sts.is_last, "special result not last")
	`B2RN_ASSERT_NEXT(a_last_ends, cmd.load && sts.is_last && !cmd.take, state_q == S_IDLE,
		"item still running after its last beat")

endmodule

@@ design/b2rn_dp.sv @@
// datapath of the roman numeral stream: digit split, symbol selection, output register
// depends on b2rn_pkg
module b2rn_dp import b2rn_pkg::*; (
	input  logic                clk,
	input  b2rn_cmd_t           cmd,
	input  logic [VALUE_W-1:0]  in_value,
	output b2rn_sts_t           sts,
	output logic [CHAR_W-1:0]   out_symbol_char,
	output logic [STATUS_W-1:0] out_status,
	output logic                out_last
);

	typedef enum logic [1:0] {
		SEL_ONE  = 2'd0,
		SEL_FIVE = 2'd1,
		SEL_TEN  = 2'd2
	} sel_t;

	// largest k in 0..9 with k*unit <= rem; products up to 9000 need 14 bits
	function automatic logic [3:0] digit_at(input logic [VALUE_W-1:0] rem,
	                                        input logic [VALUE_W-1:0] unit);
		logic [3:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (14'(rem) >= 14'(k) * 14'(unit)) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

	function automatic logic [2:0] digit_len(input logic [3:0] d);
		logic [2:0] n;
		case (d)
			4'd1, 4'd5:       n = 3'd1;
			4'd2, 4'd4, 4'd6,
			4'd9:             n = 3'd2;
			4'd3, 4'd7:       n = 3'd3;
			4'd8:             n = 3'd4;
			default:          n = 3'd0;
		endcase
		return n;
	endfunction

	logic [3:0]         dig_q [DIGITS];
	logic [1:0]         dec_q;
	logic [1:0]         pos_q;
	status_t            kind_q;
	logic [CHAR_W-1:0]  sym_q;
	status_t            stat_q;
	logic               last_q;

	// split of the incoming value
	logic [VALUE_W-1:0] r1, r2, r3;
	logic [3:0]         th, hu, te, on;
	logic [1:0]         top_dec;
	status_t            kind_d;

	// beat generation
	logic [3:0]         cur;
	sel_t               sel;
	logic [2:0]         len;
	logic               pos_end;
	logic               has_lower;
	logic [1:0]         next_dec;
	logic [CHAR_W-1:0]  sym_d;

	always_comb begin
		th = digit_at(in_value, 12'd1000);
		r1 = in_value - VALUE_W'(th) * 12'd1000;
		hu = digit_at(r1, 12'd100);
		r2 = r1 - VALUE_W'(hu) * 12'd100;
		te = digit_at(r2, 12'd10);
		r3 = r2 - VALUE_W'(te) * 12'd10;
		on = r3[3:0];
		if (th != '0) begin
			top_dec = 2'd3;
		end else if (hu != '0) begin
			top_dec = 2'd2;
		end else if (te != '0) begin
			top_dec = 2'd1;
		end else begin
			top_dec = 2'd0;
		end
		if (in_value == '0) begin
			kind_d = ST_ZERO;
		end else if (in_value > ROMAN_MAX) begin
			kind_d = ST_RANGE;
		end else begin
			kind_d = ST_OK;
		end
	end

	always_comb begin
		cur = dig_q[dec_q];
		len = digit_len(cur);
		case (cur) inside
			[4'd1:4'd3]: sel = SEL_ONE;
			4'd4:        sel = (pos_q == '0) ? SEL_ONE : SEL_FIVE;
			[4'd5:4'd8]: sel = (pos_q == '0) ? SEL_FIVE : SEL_ONE;
			4'd9:        sel = (pos_q == '0) ? SEL_ONE : SEL_TEN;
			default:     sel = SEL_ONE;
		endcase
		sym_d     = roman_sym({1'b0, dec_q, 1'b0} + {2'b00, sel});
		pos_end   = ({1'b0, pos_q} + 3'd1) == len;
		has_lower = 1'b0;
		next_dec  = '0;
		for (int j = 0; j < DIGITS - 1; j++) begin
			if (2'(j) < dec_q && dig_q[j] != '0) begin
				has_lower = 1'b1;
				next_dec  = 2'(j);
			end
		end
		sts.is_ok   = (kind_q == ST_OK);
		sts.is_last = !sts.is_ok || (pos_end && !has_lower);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q  <= sts.is_ok ? sym_d : '0;
			stat_q <= kind_q;
			last_q <= sts.is_last;
		end
		if (cmd.take) begin
			dig_q[3] <= th;
			dig_q[2] <= hu;
			dig_q[1] <= te;
			dig_q[0] <= on;
			dec_q    <= top_dec;
			pos_q    <= '0;
			kind_q   <= kind_d;
		end else if (cmd.load) begin
			if (pos_end) begin
				dec_q <= next_dec;
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	assign out_symbol_char = sym_q;
	assign out_status      = stat_q;
	assign out_last        = last_q;

endmodule

@@ design/binary_to_roman_numeral_stream.sv @@
// top level of the binary to roman numeral stream block
// depends on b2rn_pkg, b2rn_in_if, b2rn_out_if, b2rn_ctrl and b2rn_dp
//
//  channel | dir | payload                       | beats per item
//  --------+-----+-------------------------------+---------------
//  din     | in  | value[11:0]                   | 1
//  dout    | out | symbol_char[7:0] status last  | 1 to 15
//
// an item gives one output beat per cycle (1 to 15 beats) while dout keeps up
// the next number is taken in the cycle the final beat of the current one
// enters the output register
// zero and values above 3999 give a single beat
// arst_n clears the sequencer and the output valid; payload is not reset
// a stall on dout holds the output register; while a number is in progress din ready stays low until it drains
module binary_to_roman_numeral_stream import b2rn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	b2rn_in_if.sink    din,
	b2rn_out_if.source dout
);

	b2rn_cmd_t cmd;
	b2rn_sts_t sts;

	// sequencer: when to accept a number and when to produce a beat
	b2rn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// digit split at acceptance, then one symbol per produced beat
	b2rn_dp u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.in_value        (din.value),
		.sts             (sts),
		.out_symbol_char (dout.symbol_char),
		.out_status      (dout.status),
		.out_last        (dout.last)
	);

endmodule

@@ tb/sv/tb_binary_to_roman_numeral_stream.sv @@
// self-checking bench for binary_to_roman_numeral_stream: numbers in, roman symbol beats out
// depends on b2rn_pkg, b2rn_in_if, b2rn_out_if and the block itself
// every accepted number is turned into its expected beats and compared as they leave
module tb_binary_to_roman_numeral_stream import b2rn_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// one expected output beat
	typedef struct packed {
		logic [CHAR_W-1:0] symbol_char;
		status_t           status;
		logic              last;
	} numeral_beat_t;

	// generous ceiling: ~500 numbers, 15 beats each, heavy stalls on both sides
	localparam int CYCLE_LIMIT = 300000;
	localparam int IDLE_PCT    = 34;
	localparam int DRAIN_WAIT  = 20;
	localparam int MAX_SHOWN   = 10;

	// symbol ladder, unit/five/ten of decade d sit at 2d, 2d+1, 2d+2
	localparam logic [6:0][CHAR_W-1:0] LADDER = {SYM_M, SYM_D, SYM_C, SYM_L, SYM_X, SYM_V, SYM_I};

	logic clk;
	logic arst_n;

	b2rn_in_if  din();
	b2rn_out_if dout();

	binary_to_roman_numeral_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	// expected beats, oldest first
	numeral_beat_t numeral_q[$];

	// idling switches for sender and receiver
	bit send_idle;
	bit recv_idle;

	// bookkeeping
	int mismatch_cnt;
	int cycle_cnt;
	int numbers_taken;
	int zero_taken;
	int range_taken;
	int beats_checked;

	// clock, 10 ns period
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected beats of one accepted number, appended to the queue
	function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
		logic [CHAR_W-1:0] chars[$];
		int scale;
		int digit;
		int dec;
		int k;
		logic [CHAR_W-1:0] unit_sym;
		logic [CHAR_W-1:0] five_sym;
		logic [CHAR_W-1:0] ten_sym;
		numeral_beat_t b;

		numbers_taken++;
		if (v == '0) begin
			zero_taken++;
			b.symbol_char = '0;
			b.status      = ST_ZERO;
			b.last        = 1'b1;
			numeral_q.push_back(b);
		end else if (v > ROMAN_MAX) begin
			range_taken++;
			b.symbol_char = '0;
			b.status      = ST_RANGE;
			b.last        = 1'b1;
			numeral_q.push_back(b);
		end else begin
			scale = 1000;
			for (dec = 3; dec >= 0; dec--) begin
				digit    = (int'(v) / scale) % 10;
				unit_sym = LADDER[2 * dec];
				// thousands never go past 3, so five and ten are only read below that
				five_sym = (dec < 3) ? LADDER[2 * dec + 1] : '0;
				ten_sym  = (dec < 3) ? LADDER[2 * dec + 2] : '0;
				if (digit >= 1 && digit <= 3) begin
					for (k = 0; k < digit; k++) chars.push_back(unit_sym);
				end else if (digit == 4) begin
					chars.push_back(unit_sym);
					chars.push_back(five_sym);
				end else if (digit >= 5 && digit <= 8) begin
					chars.push_back(five_sym);
					for (k = 5; k < digit; k++) chars.push_back(unit_sym);
				end else if (digit == 9) begin
					chars.push_back(unit_sym);
					chars.push_back(ten_sym);
				end
				scale = scale / 10;
			end
			for (k = 0; k < chars.size(); k++) begin
				b.symbol_char = chars[k];
				b.status      = ST_OK;
				b.last        = (k == chars.size() - 1);
				numeral_q.push_back(b);
			end
		end
	endfunction

	// only the first few mismatches are printed in full
	task automatic report_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// monitor: predicts on every accepted number, checks every accepted beat;
	// one process so prediction and checking never race each other
	always @(posedge clk) begin : monitor
		numeral_beat_t want;

		if (arst_n) begin
			if (din.valid && din.ready)
				predict_numeral(din.value);
			if (dout.valid && dout.ready) begin
				beats_checked++;
				if (numeral_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat char=%02h status=%0d last=%0b",
						dout.symbol_char, dout.status, dout.last));
				end else begin
					want = numeral_q.pop_front();
					if (dout.symbol_char !== want.symbol_char || dout.status !== want.status
						|| dout.last !== want.last)
						report_mismatch($sformatf(
							"expected char=%02h status=%0d last=%0b, got char=%02h status=%0d last=%0b",
							want.symbol_char, want.status, want.last,
							dout.symbol_char, dout.status, dout.last));
				end
			end
		end
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, numeral_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver backpressure: ready drops in about a third of the cycles when enabled
	initial begin
		dout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (recv_idle)
				dout.ready <= ($urandom_range(99) >= IDLE_PCT);
			else
				dout.ready <= 1'b1;
		end
	end

	// send one number; returns in the time step of the edge that took it
	task automatic send_number(input logic [VALUE_W-1:0] v);
		while (send_idle && $urandom_range(99) < IDLE_PCT) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.value <= v;
		do @(posedge clk); while (!din.ready);
	endtask

	// drop valid and hold off until every expected beat has left
	// the first wait lets the monitor predict a number taken at this edge
	task automatic wait_drained();
		din.valid <= 1'b0;
		@(negedge clk);
		while (numeral_q.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// mostly real numerals, with some zero and out-of-range noise
	function automatic logic [VALUE_W-1:0] pick_number();
		int roll;

		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 15)
			return VALUE_W'($urandom_range(4095, 4000));
		else if (roll < 30)
			// long numerals: thousands 1 to 3, hundreds and ones 7 or 8, tens 3 to 8
			return VALUE_W'($urandom_range(3, 1) * 1000 + $urandom_range(8, 7) * 100
				+ $urandom_range(8, 3) * 10 + $urandom_range(8, 7));
		else
			return VALUE_W'($urandom_range(3999, 1));
	endfunction

	// extremes, many digit shapes per decade, zero and range errors
	task automatic test_directed();
		logic [VALUE_W-1:0] list[$];

		list = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd14, 12'd40, 12'd49,
			12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900, 12'd999, 12'd1000,
			12'd1994, 12'd3000, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2048};
		send_idle = 1'b1;
		recv_idle = 1'b1;
		foreach (list[i]) send_number(list[i]);
		wait_drained();
	endtask

	// random numbers with both sides idling
	task automatic test_random_stalls(input int count);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (count) send_number(pick_number());
	endtask

	// long back-to-back stretch, no idling anywhere
	task automatic test_back_to_back(input int count);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (count) send_number(pick_number());
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// bursts separated by full drains of the output
	task automatic test_drain_pauses(input int bursts);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (bursts) begin
			repeat ($urandom_range(20, 10)) send_number(pick_number());
			wait_drained();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		din.valid  <= 1'b0;
		din.value  <= '0;
		send_idle  = 1'b1;
		recv_idle  = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_stalls(220);
		test_back_to_back(110);
		test_drain_pauses(8);

		// all sent: let the tail drain, then a short settle
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d numbers (%0d zero, %0d out of range) and %0d symbol beats",
			numbers_taken, zero_taken, range_taken, beats_checked);
		$display("ran with and without stalls on both channels, %0d mismatches", mismatch_cnt);
		if (mismatch_cnt == 0 && numeral_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
